@@ rtl/itstat_pkg.sv @@
`default_nettype none

package itstat_pkg;

    localparam int SLOTS     = 20;
    localparam int TIME_BITS = 48;
    localparam int SLOT_W    = $clog2(SLOTS);
    // next-slot pointer and report walk index must also hold SLOTS itself
    localparam int CNT_W     = $clog2(SLOTS + 1);

    localparam logic [2:0] OP_INIT   = 3'd0;
    localparam logic [2:0] OP_POINT  = 3'd1;
    localparam logic [2:0] OP_CYCLE  = 3'd2;
    localparam logic [2:0] OP_REPORT = 3'd3;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_SHORT = 1'b1;

    typedef struct packed {
        logic [2:0]  func;
        logic [47:0] timestamp;
    } evt_t;

    typedef struct packed {
        logic [4:0]  slot;
        logic [31:0] interval_count;
        logic [63:0] interval_sum;
        logic [63:0] interval_sum_squares;
        logic [31:0] interval_min;
        logic [31:0] interval_max;
        logic        status;
        logic        last;
    } rpt_t;

    typedef struct packed {
        logic [31:0] count;
        logic [63:0] sum;
        logic [63:0] sum_sq;
        logic [31:0] min_iv;
        logic [31:0] max_iv;
    } stat_t;

    localparam int STAT_W = $bits(stat_t);

    localparam stat_t STAT_RESET = '{
        count:  32'd0,
        sum:    64'd0,
        sum_sq: 64'd0,
        min_iv: 32'hFFFF_FFFF,
        max_iv: 32'd0
    };

    typedef struct packed {
        logic diff_en;
        logic sq_en;
    } upd_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIFF,
        ST_SQR,
        ST_WB,
        ST_RPT_HEAD,
        ST_RPT_RD,
        ST_RPT_CHK,
        ST_RPT_LAST
    } state_t;

endpackage

`default_nettype wire

@@ rtl/itstat_ram.sv @@
`default_nettype none

module itstat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/itstat_upd.sv @@
`default_nettype none

module itstat_upd (
    input  wire logic                             clk,
    input  wire itstat_pkg::upd_ctl_t             ctl,
    input  wire logic [itstat_pkg::TIME_BITS-1:0] now,
    input  wire logic [itstat_pkg::TIME_BITS-1:0] prev_stamp,
    input  wire itstat_pkg::stat_t                cur,
    output itstat_pkg::stat_t                     nxt
);

    import itstat_pkg::*;

    logic [TIME_BITS-1:0] diff;
    logic [63:0]          diff_wide;
    logic [31:0]          iv_next;
    logic [31:0]          iv_reg;
    logic [63:0]          sq_next;
    logic [63:0]          sq_reg;
    logic [64:0]          sum_wide;
    logic [64:0]          sq_sum_wide;

    // wraps modulo 2^TIME_BITS, then clamps to 32 bits
    assign diff      = now - prev_stamp;
    assign diff_wide = 64'(diff);
    assign iv_next   = (|diff_wide[63:32]) ? 32'hFFFF_FFFF : diff_wide[31:0];
    assign sq_next   = iv_reg * iv_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.diff_en)
        begin
            iv_reg <= iv_next;
        end
        if (ctl.sq_en)
        begin
            sq_reg <= sq_next;
        end
    end

    assign sum_wide    = {1'b0, cur.sum} + {33'd0, iv_reg};
    assign sq_sum_wide = {1'b0, cur.sum_sq} + {1'b0, sq_reg};

    always_comb
    begin
        nxt.sum    = sum_wide[64] ? '1 : sum_wide[63:0];
        nxt.sum_sq = sq_sum_wide[64] ? '1 : sq_sum_wide[63:0];
        nxt.min_iv = (iv_reg < cur.min_iv) ? iv_reg : cur.min_iv;
        nxt.max_iv = (iv_reg > cur.max_iv) ? iv_reg : cur.max_iv;
        nxt.count  = (&cur.count) ? cur.count : cur.count + 32'd1;
    end

endmodule

`default_nettype wire

@@ rtl/interval_time_statistics_core.sv @@
`default_nettype none

// Interval profiler over SLOTS time-point slots. Each event transaction carries an
// operation and a timestamp; per-slot stamps and statistics live in two
// single-port-read RAMs (stamp RAM and statistics RAM) with registered reads, and
// per-slot valid flops make init take effect at once, so no clearing pass follows
// reset or init. Init, disable and ignored events are handled in the idle state.
// Record point and new cycle each step through RAM read, interval difference,
// 32x32 square, then the saturating accumulate written back to both RAMs.
// A report reads slot 0 at the head into a held copy, then walks the statistics
// RAM one slot at a time (read, then emit) until a read finds the first empty
// slot or every slot is in use, and closes with slot 0 from the held copy;
// rpt_ready held low stalls it. A report with too few cycles emits only slot 0.
// The next event is taken in the cycle after the last result is loaded into the
// output register.
module interval_time_statistics_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              evt_valid,
    output logic                   evt_ready,
    input  wire itstat_pkg::evt_t  evt,
    output logic                   rpt_valid,
    input  wire logic              rpt_ready,
    output itstat_pkg::rpt_t       rpt
);

    import itstat_pkg::*;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     next_slot_reg, next_slot_next;
    logic                 logging_reg, logging_next;
    logic [SLOTS-1:0]     valid_reg, valid_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    logic                 is_cycle_reg, is_cycle_next;
    logic [SLOT_W-1:0]    wslot_reg, wslot_next;
    logic [TIME_BITS-1:0] now_reg;
    stat_t                hold0_reg;
    logic                 hold0_load;
    logic                 stamp_vld_reg, stats_vld_reg;
    logic                 rpt_valid_reg;
    rpt_t                 rpt_reg, rpt_next;
    logic                 rpt_load;

    logic                 accept;
    logic                 out_free;
    logic                 point_ok;
    logic [CNT_W-1:0]     ns_m1;
    logic [TIME_BITS-1:0] now_in;

    logic                 stamp_re, stats_re, mem_we;
    logic [SLOT_W-1:0]    stamp_raddr, stats_raddr;
    logic [TIME_BITS-1:0] stamp_rdata, stamp_q;
    logic [STAT_W-1:0]    stats_rdata;
    stat_t                stats_q, stats_upd, stats_wr;
    upd_ctl_t             upd_ctl;

    assign accept    = evt_valid && evt_ready;
    assign out_free  = !rpt_valid_reg || rpt_ready;
    assign now_in    = TIME_BITS'(evt.timestamp);
    assign ns_m1     = next_slot_reg - 1'b1;
    assign point_ok  = logging_reg && (next_slot_reg != '0)
                       && (next_slot_reg < CNT_W'(SLOTS));

    // entries not written since init read as their reset values
    assign stamp_q   = stamp_vld_reg ? stamp_rdata : '0;
    assign stats_q   = stats_vld_reg ? stat_t'(stats_rdata) : STAT_RESET;

    // new cycle with no earlier stamp only stamps slot 0
    assign stats_wr  = (!is_cycle_reg || stamp_vld_reg) ? stats_upd : stats_q;

    itstat_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (SLOTS)
    ) u_stamp_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (wslot_reg),
        .wdata (now_reg),
        .re    (stamp_re),
        .raddr (stamp_raddr),
        .rdata (stamp_rdata)
    );

    itstat_ram #(
        .WIDTH (STAT_W),
        .DEPTH (SLOTS)
    ) u_stats_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (wslot_reg),
        .wdata (STAT_W'(stats_wr)),
        .re    (stats_re),
        .raddr (stats_raddr),
        .rdata (stats_rdata)
    );

    itstat_upd u_upd (
        .clk        (clk),
        .ctl        (upd_ctl),
        .now        (now_reg),
        .prev_stamp (stamp_q),
        .cur        (stats_q),
        .nxt        (stats_upd)
    );

    always_comb
    begin
        state_next     = state_reg;
        next_slot_next = next_slot_reg;
        logging_next   = logging_reg;
        valid_next     = valid_reg;
        idx_next       = idx_reg;
        is_cycle_next  = is_cycle_reg;
        wslot_next     = wslot_reg;
        hold0_load     = 1'b0;
        stamp_re       = 1'b0;
        stats_re       = 1'b0;
        stamp_raddr    = '0;
        stats_raddr    = '0;
        mem_we         = 1'b0;
        upd_ctl        = '0;
        rpt_load       = 1'b0;
        rpt_next       = '0;
        evt_ready      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                evt_ready = 1'b1;
                if (evt_valid)
                begin
                    priority if (evt.func == OP_INIT)
                    begin
                        valid_next     = '0;
                        next_slot_next = '0;
                        logging_next   = 1'b1;
                    end
                    else if (evt.func == OP_POINT)
                    begin
                        if (point_ok)
                        begin
                            stamp_re       = 1'b1;
                            stamp_raddr    = ns_m1[SLOT_W-1:0];
                            stats_re       = 1'b1;
                            stats_raddr    = next_slot_reg[SLOT_W-1:0];
                            wslot_next     = next_slot_reg[SLOT_W-1:0];
                            is_cycle_next  = 1'b0;
                            next_slot_next = next_slot_reg + 1'b1;
                            state_next     = ST_DIFF;
                        end
                    end
                    else if (evt.func == OP_CYCLE)
                    begin
                        if (logging_reg)
                        begin
                            stamp_re       = 1'b1;
                            stats_re       = 1'b1;
                            wslot_next     = '0;
                            is_cycle_next  = 1'b1;
                            next_slot_next = CNT_W'(1);
                            state_next     = ST_DIFF;
                        end
                    end
                    else if (evt.func == OP_REPORT)
                    begin
                        if (logging_reg)
                        begin
                            stats_re   = 1'b1;
                            state_next = ST_RPT_HEAD;
                        end
                    end
                    else
                    begin
                        // disable and the unused codes
                        logging_next = 1'b0;
                    end
                end
            end

            ST_DIFF:
            begin
                upd_ctl.diff_en = 1'b1;
                state_next      = ST_SQR;
            end

            ST_SQR:
            begin
                upd_ctl.sq_en = 1'b1;
                state_next    = ST_WB;
            end

            ST_WB:
            begin
                mem_we                = 1'b1;
                valid_next[wslot_reg] = 1'b1;
                state_next            = ST_IDLE;
            end

            ST_RPT_HEAD:
            begin
                if (stats_q.count < 32'd2)
                begin
                    if (out_free)
                    begin
                        rpt_load                      = 1'b1;
                        rpt_next.slot                 = '0;
                        rpt_next.interval_count       = stats_q.count;
                        rpt_next.interval_sum         = stats_q.sum;
                        rpt_next.interval_sum_squares = stats_q.sum_sq;
                        rpt_next.interval_min         = stats_q.min_iv;
                        rpt_next.interval_max         = stats_q.max_iv;
                        rpt_next.status               = STATUS_SHORT;
                        rpt_next.last                 = 1'b1;
                        state_next                    = ST_IDLE;
                    end
                end
                else
                begin
                    hold0_load = 1'b1;
                    idx_next   = CNT_W'(1);
                    state_next = ST_RPT_RD;
                end
            end

            ST_RPT_RD:
            begin
                if (idx_reg == CNT_W'(SLOTS))
                begin
                    state_next = ST_RPT_LAST;
                end
                else
                begin
                    stats_re    = 1'b1;
                    stats_raddr = idx_reg[SLOT_W-1:0];
                    state_next  = ST_RPT_CHK;
                end
            end

            ST_RPT_CHK:
            begin
                if (stats_q.count == '0)
                begin
                    state_next = ST_RPT_LAST;
                end
                else if (out_free)
                begin
                    rpt_load                      = 1'b1;
                    rpt_next.slot                 = 5'(idx_reg);
                    rpt_next.interval_count       = stats_q.count;
                    rpt_next.interval_sum         = stats_q.sum;
                    rpt_next.interval_sum_squares = stats_q.sum_sq;
                    rpt_next.interval_min         = stats_q.min_iv;
                    rpt_next.interval_max         = stats_q.max_iv;
                    rpt_next.status               = STATUS_OK;
                    rpt_next.last                 = 1'b0;
                    idx_next                      = idx_reg + 1'b1;
                    state_next                    = ST_RPT_RD;
                end
            end

            ST_RPT_LAST:
            begin
                if (out_free)
                begin
                    rpt_load                      = 1'b1;
                    rpt_next.slot                 = '0;
                    rpt_next.interval_count       = hold0_reg.count;
                    rpt_next.interval_sum         = hold0_reg.sum;
                    rpt_next.interval_sum_squares = hold0_reg.sum_sq;
                    rpt_next.interval_min         = hold0_reg.min_iv;
                    rpt_next.interval_max         = hold0_reg.max_iv;
                    rpt_next.status               = STATUS_OK;
                    rpt_next.last                 = 1'b1;
                    logging_next                  = 1'b0;
                    state_next                    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            next_slot_reg <= '0;
            logging_reg   <= 1'b0;
            valid_reg     <= '0;
            rpt_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            next_slot_reg <= next_slot_next;
            logging_reg   <= logging_next;
            valid_reg     <= valid_next;
            if (rpt_load)
            begin
                rpt_valid_reg <= 1'b1;
            end
            else if (rpt_ready)
            begin
                rpt_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        is_cycle_reg <= is_cycle_next;
        wslot_reg    <= wslot_next;
        if (accept)
        begin
            now_reg <= now_in;
        end
        if (stamp_re)
        begin
            stamp_vld_reg <= valid_reg[stamp_raddr];
        end
        if (stats_re)
        begin
            stats_vld_reg <= valid_reg[stats_raddr];
        end
        if (hold0_load)
        begin
            hold0_reg <= stats_q;
        end
        if (rpt_load)
        begin
            rpt_reg <= rpt_next;
        end
    end

    assign rpt_valid = rpt_valid_reg;
    assign rpt       = rpt_reg;

endmodule

`default_nettype wire

@@ rtl/itstat_chk.sv @@
`default_nettype none

module itstat_chk (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             evt_valid,
    input  wire logic             evt_ready,
    input  wire itstat_pkg::evt_t evt,
    input  wire logic             rpt_valid,
    input  wire logic             rpt_ready,
    input  wire itstat_pkg::rpt_t rpt
);

    import itstat_pkg::*;

    // a stalled event transaction holds
    a_evt_hold: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && !evt_ready |=> evt_valid && $stable(evt))
        else $error("event changed while stalled");

    // a stalled result transaction holds
    a_rpt_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rpt_valid && !rpt_ready |=> rpt_valid && $stable(rpt))
        else $error("result changed while stalled");

    // short-data status only on the lone slot 0 result
    a_short_last: assert property (@(posedge clk) disable iff (!rst_n)
        rpt_valid && rpt.status == STATUS_SHORT |-> rpt.last && rpt.slot == '0)
        else $error("short status on a non-final result");

    // slot 0 closes a report, everything before it is a higher slot with good status
    a_walk_order: assert property (@(posedge clk) disable iff (!rst_n)
        rpt_valid && !rpt.last |-> rpt.slot != '0 && rpt.status == STATUS_OK)
        else $error("slot 0 or short status inside a report walk");

    // an empty slot must still carry its cleared values
    a_empty_slot: assert property (@(posedge clk) disable iff (!rst_n)
        rpt_valid && rpt.interval_count == '0 |->
            rpt.interval_sum == '0 && rpt.interval_sum_squares == '0
            && rpt.interval_max == '0 && rpt.interval_min == '1)
        else $error("empty slot with stale statistics");

endmodule

bind interval_time_statistics_core itstat_chk u_itstat_chk (.*);

`default_nettype wire
